// ===== rtl/core/sbm_pkg.sv =====
// shared types and constants of the stereo block matching unit
package sbm_pkg;

    // fixed field widths
    localparam int PIX_W   = 8;
    localparam int COORD_W = 9;
    localparam int OUT_W   = 19;
    localparam int CFG_W   = 10;
    localparam int IDX_W   = 3;
    localparam int FRAC_W  = 8;
    localparam int QUO_W   = 9;

    // one half in the output fixed point format
    localparam int HALF_STEP = 128;

    // configuration register indexes
    localparam logic [IDX_W-1:0] CFG_BLOCK_SIZE  = 3'd0;
    localparam logic [IDX_W-1:0] CFG_LEFT_STEPS  = 3'd1;
    localparam logic [IDX_W-1:0] CFG_RIGHT_STEPS = 3'd2;
    localparam logic [IDX_W-1:0] CFG_IMG_WIDTH   = 3'd3;
    localparam logic [IDX_W-1:0] CFG_IMG_HEIGHT  = 3'd4;

    // operation codes
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_GEO1,
        S_GEO2,
        S_GEO3,
        S_GEO4,
        S_ROWBASE,
        S_LOAD,
        S_STREAM,
        S_DRAIN,
        S_PREP1,
        S_PREP2,
        S_DIV,
        S_FIN,
        S_RESULT
    } state_t;

    // controls shared by every cell of the chain
    typedef struct packed {
        logic shift;
        logic accum;
    } cell_ctrl_t;

endpackage

// ===== rtl/core/sbm_ram.sv =====
// generic simple dual port ram with registered read
module sbm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/sbm_cell.sv =====
// one window column cell: holds a left pixel and adds its abs difference to the partial sum
module sbm_cell #(
    parameter int PSW = 12
) (
    input  logic                      clk,
    input  sbm_pkg::cell_ctrl_t       ctrl,
    input  logic [sbm_pkg::PIX_W-1:0] pix_in,
    input  logic [sbm_pkg::PIX_W-1:0] probe,
    input  logic [PSW-1:0]            psum_in,
    output logic [sbm_pkg::PIX_W-1:0] pix_out,
    output logic [PSW-1:0]            psum_out
);

    logic [sbm_pkg::PIX_W-1:0] left_reg;
    logic [PSW-1:0]            psum_reg;
    logic [sbm_pkg::PIX_W-1:0] diff;

    // absolute difference against the broadcast right pixel
    assign diff = (left_reg > probe) ? (left_reg - probe) : (probe - left_reg);

    // left pixel shift and partial sum hand-off
    always_ff @(posedge clk)
    begin
        if (ctrl.shift)
        begin
            left_reg <= pix_in;
        end
        if (ctrl.accum)
        begin
            psum_reg <= psum_in + PSW'(diff);
        end
    end

    assign pix_out  = left_reg;
    assign psum_out = psum_reg;

endmodule

// ===== rtl/core/sad_block_match_disparity.sv =====
// stereo sad block matching disparity unit with parabolic subpixel refinement
// a load is written to both image stores without stalling the input; a query stalls the
// input through geometry setup, the row sweeps, the refinement divider (skipped when the
// minimum is at a scan end or is zero) and any output stall; a query outside the image
// gives no result; the cell chain takes one right pixel per cycle per window row; reset
// clears control, configuration (5, 64, 64, 512, 512) and the output valid, the image
// stores and the cost buffer are not cleared
module sad_block_match_disparity #(
    parameter int MAX_WIDTH      = 512,
    parameter int MAX_HEIGHT     = 512,
    parameter int MAX_CANDIDATES = 512,
    parameter int MAX_BLOCK      = 15
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                op,
    input  logic [sbm_pkg::COORD_W-1:0]         pixel_x,
    input  logic [sbm_pkg::COORD_W-1:0]         pixel_y,
    input  logic [sbm_pkg::PIX_W-1:0]           left_pixel,
    input  logic [sbm_pkg::PIX_W-1:0]           right_pixel,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [sbm_pkg::OUT_W-1:0]    disparity_value,
    output logic [sbm_pkg::COORD_W-1:0]         result_x,
    output logic [sbm_pkg::COORD_W-1:0]         result_y,
    input  logic                                cfg_we,
    input  logic [sbm_pkg::IDX_W-1:0]           cfg_index,
    input  logic [sbm_pkg::CFG_W-1:0]           cfg_data
);

    localparam int AW       = $clog2(MAX_WIDTH * MAX_HEIGHT);
    localparam int KW       = $clog2(MAX_CANDIDATES);
    localparam int HALF_MAX = (MAX_BLOCK - 1) / 2;
    localparam int SW       = (MAX_BLOCK > 1) ? $clog2(MAX_BLOCK) : 1;
    localparam int PSW      = $clog2(MAX_BLOCK * 255 + 1);
    localparam int CSW      = $clog2(MAX_BLOCK * MAX_BLOCK * 255 + 1);
    localparam int MAXD     = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
    localparam int GW       = $clog2(MAXD + MAX_CANDIDATES + 1024) + 1;
    localparam int NW       = CSW + 12;
    localparam int OW       = sbm_pkg::OUT_W;

    localparam logic signed [GW-1:0] G_ZERO  = GW'(0);
    localparam logic signed [GW-1:0] G_ONE   = GW'(1);
    localparam logic signed [GW-1:0] MW_G    = GW'(MAX_WIDTH);
    localparam logic signed [GW-1:0] MH_G    = GW'(MAX_HEIGHT);
    localparam logic signed [GW-1:0] HM_G    = GW'(HALF_MAX);
    localparam logic signed [GW-1:0] MC_M1_G = GW'(MAX_CANDIDATES - 1);
    localparam logic [31:0]          MW32    = 32'(MAX_WIDTH);
    localparam logic [31:0]          MH32    = 32'(MAX_HEIGHT);

    function automatic logic signed [GW-1:0] smin(input logic signed [GW-1:0] a,
                                                  input logic signed [GW-1:0] b);
        smin = (a < b) ? a : b;
    endfunction

    function automatic logic signed [GW-1:0] smax(input logic signed [GW-1:0] a,
                                                  input logic signed [GW-1:0] b);
        smax = (a > b) ? a : b;
    endfunction

    sbm_pkg::state_t state_reg, state_next;

    // configuration registers
    logic [3:0]                bs_reg;
    logic [7:0]                ls_reg;
    logic [7:0]                rs_reg;
    logic [sbm_pkg::CFG_W-1:0] iw_reg;
    logic [sbm_pkg::CFG_W-1:0] ih_reg;

    // query geometry
    logic [sbm_pkg::COORD_W-1:0] qx_reg, qy_reg;
    logic signed [GW-1:0] w_reg, h_reg, half_reg;
    logic signed [GW-1:0] lh_reg, rh_reg, th_reg, bh_reg;
    logic signed [GW-1:0] tw_reg, tht_reg, top_reg, lx_reg, lo_reg, hi1_reg;
    logic signed [GW-1:0] steps_reg, zero_reg;
    logic signed [GW-1:0] r_reg, c_reg, j_reg, bj_reg;
    logic [AW-1:0]        row_base_reg;

    // stream pipeline
    logic          lv_reg, lv_next;
    logic          bv_reg, bv_next;
    logic          cv_reg, cv_next;
    logic [KW-1:0] ck_reg;

    // minimum tracking
    logic [KW-1:0]  best_reg;
    logic [CSW-1:0] bsad_reg, c1_reg, c3_reg, prev_reg;
    logic           pend_reg;

    // refinement divider
    logic signed [NW-1:0]      den_reg;
    logic [NW-1:0]             rem_reg, dsh_reg;
    logic [3:0]                i_reg;
    logic [sbm_pkg::QUO_W-1:0] q_reg;
    logic signed [OW-1:0]      val_reg;

    // output register
    logic                        out_valid_reg, out_valid_next;
    logic signed [OW-1:0]        outd_reg;
    logic [sbm_pkg::COORD_W-1:0] outx_reg, outy_reg;

    logic signed [GW-1:0] gx, gy, iw_g, ih_g, ls_g, rs_g, half_g, w_clamp, h_clamp;
    logic signed [GW-1:0] tw_c, hi_c, last_j, best_g, offset_g;
    logic [2:0]           hb;
    logic                 in_acc, out_free, last_row, first_row, skip, pipe_empty;

    // memory ports
    logic                      st_we;
    logic [AW-1:0]             st_waddr, l_raddr, r_raddr;
    logic [sbm_pkg::PIX_W-1:0] l_rdata, r_rdata;
    logic [KW-1:0]             cost_raddr;
    logic [CSW-1:0]            cost_rdata, cost;

    // chain wiring
    sbm_pkg::cell_ctrl_t       cell_ctrl;
    logic [sbm_pkg::PIX_W-1:0] chain_pix [MAX_BLOCK];
    logic [PSW-1:0]            chain_sum [MAX_BLOCK];
    logic [PSW-1:0]            row_sad;

    logic signed [NW-1:0] c1_e, c2_e, c3_e;

    // handshake
    assign in_stall = (state_reg != sbm_pkg::S_IDLE);
    assign in_acc   = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;

    // geometry helpers
    assign gx      = $signed({{(GW - sbm_pkg::COORD_W){1'b0}}, qx_reg});
    assign gy      = $signed({{(GW - sbm_pkg::COORD_W){1'b0}}, qy_reg});
    assign iw_g    = $signed({{(GW - sbm_pkg::CFG_W){1'b0}}, iw_reg});
    assign ih_g    = $signed({{(GW - sbm_pkg::CFG_W){1'b0}}, ih_reg});
    assign ls_g    = $signed({{(GW - 8){1'b0}}, ls_reg});
    assign rs_g    = $signed({{(GW - 8){1'b0}}, rs_reg});
    assign hb      = (bs_reg == 4'd0) ? 3'd0 : 3'((bs_reg - 4'd1) >> 1);
    assign half_g  = $signed({{(GW - 3){1'b0}}, hb});
    assign w_clamp = (iw_g == G_ZERO) ? G_ONE : ((iw_g > MW_G) ? MW_G : iw_g);
    assign h_clamp = (ih_g == G_ZERO) ? G_ONE : ((ih_g > MH_G) ? MH_G : ih_g);
    assign tw_c    = lh_reg + rh_reg + G_ONE;
    assign hi_c    = smin(hi1_reg, lo_reg + MC_M1_G);
    assign last_j  = steps_reg + tw_reg - G_ONE;

    assign last_row   = (r_reg == tht_reg - G_ONE);
    assign first_row  = (r_reg == G_ZERO);
    assign pipe_empty = !bv_reg && !cv_reg;

    // final decision helpers
    assign best_g   = $signed({{(GW - KW){1'b0}}, best_reg});
    assign offset_g = (best_g > zero_reg) ? (best_g - zero_reg) : (zero_reg - best_g);
    assign skip     = (best_reg == '0) || (best_g == steps_reg) || (bsad_reg == '0);
    assign c1_e     = $signed({{(NW - CSW){1'b0}}, c1_reg});
    assign c2_e     = $signed({{(NW - CSW){1'b0}}, bsad_reg});
    assign c3_e     = $signed({{(NW - CSW){1'b0}}, c3_reg});

    // image stores
    assign st_we    = in_acc && (op == sbm_pkg::OP_LOAD)
                      && ({23'd0, pixel_x} < MW32) && ({23'd0, pixel_y} < MH32);
    assign st_waddr = AW'(pixel_y) * AW'(MAX_WIDTH) + AW'(pixel_x);
    assign l_raddr  = row_base_reg + AW'(lx_reg + c_reg);
    assign r_raddr  = row_base_reg + AW'(lo_reg + j_reg);

    sbm_ram #(.WIDTH(sbm_pkg::PIX_W), .DEPTH(MAX_WIDTH * MAX_HEIGHT)) u_left_store (
        .clk   (clk),
        .we    (st_we),
        .waddr (st_waddr),
        .wdata (left_pixel),
        .raddr (l_raddr),
        .rdata (l_rdata)
    );

    sbm_ram #(.WIDTH(sbm_pkg::PIX_W), .DEPTH(MAX_WIDTH * MAX_HEIGHT)) u_right_store (
        .clk   (clk),
        .we    (st_we),
        .waddr (st_waddr),
        .wdata (right_pixel),
        .raddr (r_raddr),
        .rdata (r_rdata)
    );

    // cell chain: left pixels shift in, partial sums move one cell per right pixel
    assign cell_ctrl.shift = lv_reg;
    assign cell_ctrl.accum = bv_reg;

    for (genvar g = 0; g < MAX_BLOCK; g++)
    begin : g_cell
        if (g == 0)
        begin : g_head
            sbm_cell #(.PSW(PSW)) u_cell (
                .clk      (clk),
                .ctrl     (cell_ctrl),
                .pix_in   (l_rdata),
                .probe    (r_rdata),
                .psum_in  ({PSW{1'b0}}),
                .pix_out  (chain_pix[g]),
                .psum_out (chain_sum[g])
            );
        end
        else
        begin : g_body
            sbm_cell #(.PSW(PSW)) u_cell (
                .clk      (clk),
                .ctrl     (cell_ctrl),
                .pix_in   (chain_pix[g-1]),
                .probe    (r_rdata),
                .psum_in  (chain_sum[g-1]),
                .pix_out  (chain_pix[g]),
                .psum_out (chain_sum[g])
            );
        end
    end

    assign row_sad = chain_sum[SW'(tw_reg - G_ONE)];

    // per candidate cost accumulation over window rows
    assign cost_raddr = KW'(bj_reg - (tw_reg - G_ONE));
    assign cost       = first_row ? CSW'(row_sad) : (cost_rdata + CSW'(row_sad));

    sbm_ram #(.WIDTH(CSW), .DEPTH(MAX_CANDIDATES)) u_cost_buffer (
        .clk   (clk),
        .we    (cv_reg),
        .waddr (ck_reg),
        .wdata (cost),
        .raddr (cost_raddr),
        .rdata (cost_rdata)
    );

    // state register and control flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sbm_pkg::S_IDLE;
            lv_reg        <= 1'b0;
            bv_reg        <= 1'b0;
            cv_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            lv_reg        <= lv_next;
            bv_reg        <= bv_next;
            cv_reg        <= cv_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // next state and control
    always_comb
    begin
        state_next     = state_reg;
        lv_next        = (state_reg == sbm_pkg::S_LOAD);
        bv_next        = (state_reg == sbm_pkg::S_STREAM);
        cv_next        = bv_reg && (bj_reg >= tw_reg - G_ONE);
        out_valid_next = out_valid_reg && out_stall;
        case (state_reg)
            sbm_pkg::S_IDLE:
            begin
                if (in_acc && (op == sbm_pkg::OP_QUERY))
                begin
                    state_next = sbm_pkg::S_GEO1;
                end
            end
            sbm_pkg::S_GEO1:    state_next = sbm_pkg::S_GEO2;
            sbm_pkg::S_GEO2:
            begin
                if ((gx >= w_reg) || (gy >= h_reg))
                begin
                    state_next = sbm_pkg::S_IDLE;
                end
                else
                begin
                    state_next = sbm_pkg::S_GEO3;
                end
            end
            sbm_pkg::S_GEO3:    state_next = sbm_pkg::S_GEO4;
            sbm_pkg::S_GEO4:    state_next = sbm_pkg::S_ROWBASE;
            sbm_pkg::S_ROWBASE: state_next = sbm_pkg::S_LOAD;
            sbm_pkg::S_LOAD:
            begin
                if (c_reg == G_ZERO)
                begin
                    state_next = sbm_pkg::S_STREAM;
                end
            end
            sbm_pkg::S_STREAM:
            begin
                if (j_reg == last_j)
                begin
                    state_next = sbm_pkg::S_DRAIN;
                end
            end
            sbm_pkg::S_DRAIN:
            begin
                if (pipe_empty)
                begin
                    state_next = last_row ? sbm_pkg::S_PREP1 : sbm_pkg::S_ROWBASE;
                end
            end
            sbm_pkg::S_PREP1:
            begin
                state_next = skip ? sbm_pkg::S_RESULT : sbm_pkg::S_PREP2;
            end
            sbm_pkg::S_PREP2:   state_next = sbm_pkg::S_DIV;
            sbm_pkg::S_DIV:
            begin
                if (i_reg == 4'd0)
                begin
                    state_next = sbm_pkg::S_FIN;
                end
            end
            sbm_pkg::S_FIN:     state_next = sbm_pkg::S_RESULT;
            sbm_pkg::S_RESULT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    state_next     = sbm_pkg::S_IDLE;
                end
            end
            default:            state_next = sbm_pkg::S_IDLE;
        endcase
    end

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bs_reg <= 4'd5;
            ls_reg <= 8'd64;
            rs_reg <= 8'd64;
            iw_reg <= 10'd512;
            ih_reg <= 10'd512;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                sbm_pkg::CFG_BLOCK_SIZE:  bs_reg <= cfg_data[3:0];
                sbm_pkg::CFG_LEFT_STEPS:  ls_reg <= cfg_data[7:0];
                sbm_pkg::CFG_RIGHT_STEPS: rs_reg <= cfg_data[7:0];
                sbm_pkg::CFG_IMG_WIDTH:   iw_reg <= cfg_data;
                sbm_pkg::CFG_IMG_HEIGHT:  ih_reg <= cfg_data;
                default:                  ;
            endcase
        end
    end

    // query datapath
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            qx_reg <= pixel_x;
            qy_reg <= pixel_y;
        end

        // window and scan range setup
        if (state_reg == sbm_pkg::S_GEO1)
        begin
            w_reg    <= w_clamp;
            h_reg    <= h_clamp;
            half_reg <= smin(half_g, HM_G);
        end
        if (state_reg == sbm_pkg::S_GEO2)
        begin
            lh_reg <= smin(gx, half_reg);
            rh_reg <= smin(w_reg - gx - G_ONE, half_reg);
            th_reg <= smin(gy, half_reg);
            bh_reg <= smin(h_reg - gy - G_ONE, half_reg);
        end
        if (state_reg == sbm_pkg::S_GEO3)
        begin
            tw_reg  <= tw_c;
            tht_reg <= th_reg + bh_reg + G_ONE;
            top_reg <= gy - th_reg;
            lx_reg  <= gx - lh_reg;
            lo_reg  <= smax(G_ZERO, gx - ls_g - lh_reg);
            hi1_reg <= smin(w_reg - tw_c, gx + rs_g - lh_reg);
        end
        if (state_reg == sbm_pkg::S_GEO4)
        begin
            steps_reg <= hi_c - lo_reg;
            zero_reg  <= gx - lo_reg - lh_reg;
            r_reg     <= G_ZERO;
        end

        // row sweep counters
        if (state_reg == sbm_pkg::S_ROWBASE)
        begin
            row_base_reg <= AW'(top_reg + r_reg) * AW'(MAX_WIDTH);
            c_reg        <= tw_reg - G_ONE;
        end
        if (state_reg == sbm_pkg::S_LOAD)
        begin
            c_reg <= c_reg - G_ONE;
            j_reg <= G_ZERO;
        end
        if (state_reg == sbm_pkg::S_STREAM)
        begin
            j_reg <= j_reg + G_ONE;
        end
        if ((state_reg == sbm_pkg::S_DRAIN) && pipe_empty && !last_row)
        begin
            r_reg <= r_reg + G_ONE;
        end

        // stream pipeline tags
        bj_reg <= j_reg;
        ck_reg <= cost_raddr;

        // first minimum and its neighbors on the final row
        if (cv_reg && last_row)
        begin
            prev_reg <= cost;
            if ((ck_reg == '0) || (cost < bsad_reg))
            begin
                best_reg <= ck_reg;
                bsad_reg <= cost;
                c1_reg   <= prev_reg;
                pend_reg <= 1'b1;
            end
            else if (pend_reg)
            begin
                c3_reg   <= cost;
                pend_reg <= 1'b0;
            end
        end

        // integer disparity and parabola denominator
        if (state_reg == sbm_pkg::S_PREP1)
        begin
            val_reg <= OW'(offset_g) <<< sbm_pkg::FRAC_W;
            den_reg <= c1_e - (c2_e <<< 1) + c3_e;
        end
        // offset dividend so that the quotient is never negative
        if (state_reg == sbm_pkg::S_PREP2)
        begin
            rem_reg <= NW'((den_reg <<< sbm_pkg::FRAC_W) + den_reg
                           + ((c1_e - c3_e) <<< sbm_pkg::FRAC_W));
            dsh_reg <= NW'(den_reg <<< (sbm_pkg::FRAC_W + 1));
            i_reg   <= 4'(sbm_pkg::QUO_W - 1);
            q_reg   <= '0;
        end
        // restoring division, one quotient bit per cycle
        if (state_reg == sbm_pkg::S_DIV)
        begin
            if (rem_reg >= dsh_reg)
            begin
                rem_reg <= rem_reg - dsh_reg;
            end
            q_reg   <= {q_reg[sbm_pkg::QUO_W-2:0], (rem_reg >= dsh_reg)};
            dsh_reg <= dsh_reg >> 1;
            i_reg   <= i_reg - 4'd1;
        end
        if (state_reg == sbm_pkg::S_FIN)
        begin
            val_reg <= val_reg + OW'(q_reg) - OW'(sbm_pkg::HALF_STEP);
        end

        // output item register
        if ((state_reg == sbm_pkg::S_RESULT) && out_free)
        begin
            outd_reg <= val_reg;
            outx_reg <= qx_reg;
            outy_reg <= qy_reg;
        end
    end

    assign out_valid       = out_valid_reg;
    assign disparity_value = outd_reg;
    assign result_x        = outx_reg;
    assign result_y        = outy_reg;

endmodule
